// File: sv/csvtok_pkg.sv
`timescale 1ns / 1ps

package csvtok_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned RES_MAX   = 3;
	localparam int unsigned RES_CNT_W = 2;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

	localparam logic [CHAR_W-1:0] DELIM_A_RESET = 8'h09;
	localparam logic [CHAR_W-1:0] DELIM_B_RESET = 8'h0A;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_A = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_B = 1'b1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// All results caused by one byte, slot 0 first.
	typedef struct packed {
		logic [RES_CNT_W-1:0]             count;
		logic [RES_MAX-1:0]               kind;
		logic [RES_MAX-1:0][CHAR_W-1:0]   chr;
	} res_bundle_t;

endpackage

// File: sv/csvtok_if.sv
`timescale 1ns / 1ps

interface csvtok_byte_if;
	logic                         valid;
	logic                         ready;
	logic [csvtok_pkg::CHAR_W-1:0] byte_value;
	logic                         line_last;

	modport source (output valid, output byte_value, output line_last, input ready);
	modport sink   (input valid, input byte_value, input line_last, output ready);
endinterface

interface csvtok_token_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [csvtok_pkg::CHAR_W-1:0] char_out;
	logic                         run_last;

	modport source (output valid, output kind, output char_out, output run_last, input ready);
	modport sink   (input valid, input kind, input char_out, input run_last, output ready);
endinterface

// File: sv/csvtok_step.sv
`timescale 1ns / 1ps

module csvtok_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [csvtok_pkg::CHAR_W-1:0] byte_value,
	input  logic                          line_last,
	input  logic [csvtok_pkg::CHAR_W-1:0] delim_a,
	input  logic [csvtok_pkg::CHAR_W-1:0] delim_b,
	output csvtok_pkg::res_bundle_t       bundle
);

	typedef enum logic [2:0] {
		MODE_IDLE       = 3'd0,
		MODE_PLAIN      = 3'd1,
		MODE_QUOTED     = 3'd2,
		MODE_QUOTE_SEEN = 3'd3,
		MODE_CR_SEEN    = 3'd4,
		MODE_STOPPED    = 3'd5
	} mode_t;

	mode_t mode_q;
	mode_t mode_nxt;

	always_comb begin
		logic                                is_delim;
		logic                                do_uq;
		logic                                uq_start;
		logic [csvtok_pkg::RES_CNT_W-1:0]    n;
		csvtok_pkg::res_bundle_t             r;
		mode_t                               nm;

		is_delim = (byte_value == csvtok_pkg::CHAR_COMMA) ||
		           (byte_value == csvtok_pkg::CHAR_TAB) ||
		           ((delim_a != csvtok_pkg::CHAR_NUL) && (byte_value == delim_a)) ||
		           ((delim_b != csvtok_pkg::CHAR_NUL) && (byte_value == delim_b));
		do_uq    = 1'b0;
		uq_start = 1'b0;
		n        = '0;
		r        = '0;
		nm       = mode_q;

		if (mode_q == MODE_STOPPED) begin
			// drop the rest of the line
		end else if (byte_value == csvtok_pkg::CHAR_NUL) begin
			if (mode_q == MODE_PLAIN || mode_q == MODE_QUOTED || mode_q == MODE_QUOTE_SEEN) begin
				r.kind[n] = csvtok_pkg::KIND_END;
				n         = n + 1'b1;
			end
			nm = MODE_STOPPED;
		end else begin
			case (mode_q)
				MODE_PLAIN: begin
					do_uq = 1'b1;
				end
				MODE_QUOTED: begin
					if (byte_value == csvtok_pkg::CHAR_QUOTE) begin
						nm = MODE_QUOTE_SEEN;
					end else begin
						r.kind[n] = csvtok_pkg::KIND_CHAR;
						r.chr[n]  = byte_value;
						n         = n + 1'b1;
					end
				end
				MODE_QUOTE_SEEN: begin
					if (byte_value == csvtok_pkg::CHAR_QUOTE) begin
						// doubled quote: one literal quote
						r.kind[n] = csvtok_pkg::KIND_CHAR;
						r.chr[n]  = csvtok_pkg::CHAR_QUOTE;
						n         = n + 1'b1;
						nm        = MODE_QUOTED;
					end else begin
						r.kind[n] = csvtok_pkg::KIND_END;
						n         = n + 1'b1;
						if (is_delim) begin
							nm = MODE_IDLE;
						end else begin
							do_uq    = 1'b1;
							uq_start = 1'b1;
						end
					end
				end
				MODE_CR_SEEN: begin
					if (byte_value == csvtok_pkg::CHAR_LF) begin
						nm = MODE_IDLE;
					end else begin
						do_uq    = 1'b1;
						uq_start = 1'b1;
					end
				end
				default: begin
					do_uq    = 1'b1;
					uq_start = 1'b1;
				end
			endcase
		end

		if (do_uq) begin
			if (uq_start && byte_value == csvtok_pkg::CHAR_QUOTE) begin
				nm = MODE_QUOTED;
			end else if (is_delim) begin
				r.kind[n] = csvtok_pkg::KIND_END;
				n         = n + 1'b1;
				nm        = MODE_IDLE;
			end else if (byte_value == csvtok_pkg::CHAR_CR) begin
				r.kind[n] = csvtok_pkg::KIND_END;
				n         = n + 1'b1;
				nm        = MODE_CR_SEEN;
			end else if (byte_value == csvtok_pkg::CHAR_LF) begin
				r.kind[n] = csvtok_pkg::KIND_END;
				n         = n + 1'b1;
				nm        = MODE_IDLE;
			end else begin
				r.kind[n] = csvtok_pkg::KIND_CHAR;
				r.chr[n]  = byte_value;
				n         = n + 1'b1;
				nm        = MODE_PLAIN;
			end
		end

		// line end closes any open token
		if (line_last) begin
			if (nm == MODE_PLAIN || nm == MODE_QUOTED || nm == MODE_QUOTE_SEEN) begin
				r.kind[n] = csvtok_pkg::KIND_END;
				n         = n + 1'b1;
			end
			nm = MODE_IDLE;
		end

		r.count  = n;
		bundle   = r;
		mode_nxt = nm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (take) begin
			mode_q <= mode_nxt;
		end
	end

endmodule

// File: sv/csvtok_obuf.sv
`timescale 1ns / 1ps

module csvtok_obuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  csvtok_pkg::res_bundle_t bundle,
	output logic                    free,
	csvtok_token_if.source          token_ch
);

	logic [csvtok_pkg::RES_CNT_W-1:0]                   cnt_q;
	logic [csvtok_pkg::RES_MAX-1:0]                     kind_q;
	logic [csvtok_pkg::RES_MAX-1:0][csvtok_pkg::CHAR_W-1:0] chr_q;
	logic pop;

	assign pop  = token_ch.valid && token_ch.ready;
	assign free = (cnt_q == '0) || ((cnt_q == 2'd1) && pop);

	assign token_ch.valid    = (cnt_q != '0);
	assign token_ch.kind     = kind_q[0];
	assign token_ch.char_out = chr_q[0];
	assign token_ch.run_last = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// advance the remaining results toward slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= bundle.kind;
			chr_q  <= bundle.chr;
		end else if (pop) begin
			kind_q <= {1'b0, kind_q[csvtok_pkg::RES_MAX-1:1]};
			chr_q  <= {{csvtok_pkg::CHAR_W{1'b0}}, chr_q[csvtok_pkg::RES_MAX-1:1]};
		end
	end

endmodule

// File: sv/quoted_csv_tokenizer.sv
`timescale 1ns / 1ps

// Quoted CSV field tokenizer. Takes one line byte per item on byte_ch, with
// line_last on the line's last byte, and returns token characters (kind 0)
// and end-of-token marks (kind 1) on token_ch; run_last flags the last
// result caused by a byte, and a byte may cause none, one, two or three.
// Comma, tab and the two delimiter registers (0 = unused) split tokens, a
// leading quote opens a quoted field with doubled quotes as literals, CR, LF
// or CRLF ends a token, and NUL closes the token and ignores the rest of the
// line. Rate: a byte enters a one-entry input register, is decoded into a
// result bundle combinationally, the bundle is loaded into a result register
// and drains one result per cycle while token_ch is ready, so the block
// takes one byte per cycle while each byte yields at most one result and
// token_ch is ready; a byte with N results holds the output until all N
// are taken. Write the delimiter registers only while no byte is in flight.
module quoted_csv_tokenizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [csvtok_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csvtok_pkg::CHAR_W-1:0]      cfg_data,
	csvtok_byte_if.sink                        byte_ch,
	csvtok_token_if.source                     token_ch
);

	logic [csvtok_pkg::CHAR_W-1:0] delim_a_q;
	logic [csvtok_pkg::CHAR_W-1:0] delim_b_q;

	logic                          valid_s1;
	logic [csvtok_pkg::CHAR_W-1:0] byte_s1;
	logic                          last_s1;

	logic                    take;
	logic                    free;
	csvtok_pkg::res_bundle_t bundle;

	// Delimiter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_a_q <= csvtok_pkg::DELIM_A_RESET;
			delim_b_q <= csvtok_pkg::DELIM_B_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csvtok_pkg::CFG_DELIM_A: delim_a_q <= cfg_data;
				csvtok_pkg::CFG_DELIM_B: delim_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the held byte once the result buffer can take its whole bundle.
	assign take          = valid_s1 && free;
	assign byte_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// Hold the payload until the byte is decoded.
	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.byte_value;
			last_s1 <= byte_ch.line_last;
		end
	end

	// Scan state and per-byte decode.
	csvtok_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_value (byte_s1),
		.line_last  (last_s1),
		.delim_a    (delim_a_q),
		.delim_b    (delim_b_q),
		.bundle     (bundle)
	);

	// Result register: drain the bundle one item per cycle while token_ch is ready.
	csvtok_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.bundle   (bundle),
		.free     (free),
		.token_ch (token_ch)
	);

endmodule

// File: sv/csvtok_checker.sv
`timescale 1ns / 1ps

module csvtok_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          kind,
	input logic [csvtok_pkg::CHAR_W-1:0] char_out,
	input logic                          run_last
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out) &&
		$stable(run_last))
		else $error("stalled result changed");

	// An end mark carries no character.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == csvtok_pkg::KIND_END |-> char_out == '0)
		else $error("end mark with nonzero character");

	// No result while in reset.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	// Results leave only by being taken.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without handshake");

endmodule

bind quoted_csv_tokenizer csvtok_checker u_csvtok_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (token_ch.valid),
	.out_ready (token_ch.ready),
	.kind      (token_ch.kind),
	.char_out  (token_ch.char_out),
	.run_last  (token_ch.run_last)
);
